@@ hdl/tsg_pkg.sv @@
// Shared types, constants and helpers for the trilinear SDF grid sampler.
package tsg_pkg;

   localparam int MAX_RES_DEFAULT    = 64;
   localparam int VALUE_BITS_DEFAULT = 32;
   localparam int FRAC_BITS          = 16;
   localparam int ISQRT_STAGES       = 32;
   localparam int CSR_INDEX_BITS     = 3;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_BOUNDS_X   = 3'd0,
      CSR_BOUNDS_Y   = 3'd1,
      CSR_BOUNDS_Z   = 3'd2,
      CSR_INV_CELL_X = 3'd3,
      CSR_INV_CELL_Y = 3'd4,
      CSR_INV_CELL_Z = 3'd5,
      CSR_GRID_RES   = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [63:0] bounds_x;
      logic [63:0] bounds_y;
      logic [63:0] bounds_z;
      logic [31:0] inv_cell_x;
      logic [31:0] inv_cell_y;
      logic [31:0] inv_cell_z;
      logic [6:0]  grid_res;
   } cfg_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_stat_type;

   // queue beat: write flag, outside flag, 8 corner addresses, write value,
   // three fractions, three box offsets
   function automatic int item_bits(input int aw, input int vb);
      return 2 + 8 * aw + vb + 3 * FRAC_BITS + 3 * 32;
   endfunction

endpackage

@@ hdl/trilinear_sdf_grid_sampler.sv @@
// Top level of the trilinear SDF grid sampler: registers, front, queue, back.
//
// Takes one beat per clock unless the queue is full, either a voxel write or
// a distance query, and returns one result beat per query in order, none for
// a write. A query passes through five front-end stages, the queue, a memory
// read, the lerp chain and a 32-stage square root that sets the latency. The
// grid is held in eight copies of MAX_RES^3 x VALUE_BITS memory, one per cube
// corner, so all eight corners are read in the same cycle; a write updates
// all copies. Voxels must be written before a query reads them. Registers may
// change only while idle.
module trilinear_sdf_grid_sampler #(
   parameter int MAX_RES    = tsg_pkg::MAX_RES_DEFAULT,
   parameter int VALUE_BITS = tsg_pkg::VALUE_BITS_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // query_x, query_y, query_z, voxel_index, voxel_value, zero pad
   input  logic [151:0] req_tdata,
   // req_type
   input  logic         req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // distance
   output logic [31:0]  rsp_tdata,
   // was_outside
   output logic         rsp_tuser,
   input  logic         csr_we,
   input  logic [tsg_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [63:0]  csr_wdata
);

   localparam int AW = 3 * $clog2(MAX_RES);
   localparam int IB = tsg_pkg::item_bits(AW, VALUE_BITS);

   tsg_pkg::cfg_type       cfg_ff;
   tsg_pkg::fifo_stat_type fifo_stat;
   logic                   fifo_push, fifo_pop;
   logic [IB-1:0]          push_data, pop_data;
   logic signed [31:0]     distance;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bounds_x   <= '0;
         cfg_ff.bounds_y   <= '0;
         cfg_ff.bounds_z   <= '0;
         cfg_ff.inv_cell_x <= 32'd65536;
         cfg_ff.inv_cell_y <= 32'd65536;
         cfg_ff.inv_cell_z <= 32'd65536;
         cfg_ff.grid_res   <= 7'd64;
      end else if (csr_we) begin
         unique case (tsg_pkg::csr_index_type'(csr_index))
            tsg_pkg::CSR_BOUNDS_X:   cfg_ff.bounds_x   <= csr_wdata;
            tsg_pkg::CSR_BOUNDS_Y:   cfg_ff.bounds_y   <= csr_wdata;
            tsg_pkg::CSR_BOUNDS_Z:   cfg_ff.bounds_z   <= csr_wdata;
            tsg_pkg::CSR_INV_CELL_X: cfg_ff.inv_cell_x <= csr_wdata[31:0];
            tsg_pkg::CSR_INV_CELL_Y: cfg_ff.inv_cell_y <= csr_wdata[31:0];
            tsg_pkg::CSR_INV_CELL_Z: cfg_ff.inv_cell_z <= csr_wdata[31:0];
            tsg_pkg::CSR_GRID_RES:   cfg_ff.grid_res   <= csr_wdata[6:0];
            default: ;
         endcase
      end
   end

   tsg_front #(.MAX_RES(MAX_RES), .VALUE_BITS(VALUE_BITS)) u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .in_write    (req_tuser),
      .query_x     (req_tdata[31:0]),
      .query_y     (req_tdata[63:32]),
      .query_z     (req_tdata[95:64]),
      .voxel_index (req_tdata[113:96]),
      .voxel_value (req_tdata[145:114]),
      .push        (fifo_push),
      .push_data   (push_data),
      .stat        (fifo_stat)
   );

   tsg_fifo #(.WIDTH(IB)) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (fifo_push),
      .push_data (push_data),
      .pop       (fifo_pop),
      .pop_data  (pop_data),
      .stat      (fifo_stat)
   );

   tsg_back #(.MAX_RES(MAX_RES), .VALUE_BITS(VALUE_BITS)) u_back (
      .clock       (clock),
      .reset       (reset),
      .pop_data    (pop_data),
      .stat        (fifo_stat),
      .pop         (fifo_pop),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .distance    (distance),
      .was_outside (rsp_tuser)
   );

   assign rsp_tdata = distance;

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      fifo_push |-> !fifo_stat.full)
      else $error("queue push while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      fifo_pop |-> !fifo_stat.empty)
      else $error("queue pop while empty");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> fifo_stat.full)
      else $error("front end stalled with room in queue");

endmodule

@@ hdl/tsg_fifo.sv @@
// Short queue between the address front end and the sampling back end.
module tsg_fifo #(
   parameter int WIDTH = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  logic [WIDTH-1:0]      push_data,
   input  logic                  pop,
   output logic [WIDTH-1:0]      pop_data,
   output tsg_pkg::fifo_stat_type stat
);

   localparam int DEPTH = 4;
   localparam int PW    = $clog2(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [PW:0]      count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop) rd_ptr_ff <= rd_ptr_ff + 1'b1;
         if (push && !pop) count_ff <= count_ff + 1'b1;
         else if (pop && !push) count_ff <= count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_data;
   end

   assign pop_data   = mem_ff[rd_ptr_ff];
   assign stat.full  = (count_ff == (PW+1)'(DEPTH));
   assign stat.empty = (count_ff == '0);

endmodule

@@ hdl/tsg_front.sv @@
// Front end: box clamp, voxel coordinates and the eight corner addresses.
module tsg_front #(
   parameter int MAX_RES    = tsg_pkg::MAX_RES_DEFAULT,
   parameter int VALUE_BITS = tsg_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  tsg_pkg::cfg_type       cfg,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic                   in_write,
   input  logic signed [31:0]     query_x,
   input  logic signed [31:0]     query_y,
   input  logic signed [31:0]     query_z,
   input  logic [17:0]            voxel_index,
   input  logic signed [31:0]     voxel_value,
   output logic                   push,
   output logic [tsg_pkg::item_bits(3*$clog2(MAX_RES), VALUE_BITS)-1:0] push_data,
   input  tsg_pkg::fifo_stat_type stat
);

   localparam int IW    = $clog2(MAX_RES);
   localparam int RW    = IW + 1;
   localparam int KW    = 2 * IW;
   localparam int AW    = 3 * IW;
   localparam int FB    = tsg_pkg::FRAC_BITS;
   localparam longint DEPTH = longint'(MAX_RES) * MAX_RES * MAX_RES;
   localparam longint VMAX  = (64'sd1 <<< (VALUE_BITS - 1)) - 1;
   localparam longint VMIN  = -VMAX - 1;

   logic en;
   logic [RW-1:0] res;
   logic [IW-1:0] res_m1;

   // stage 1: clamp and offsets
   logic signed [31:0] p [3], lo [3], hi [3];
   logic [31:0] inv [3];
   logic [31:0] ud1_in [3], ax1_in [3];
   logic        in1_in [3];
   logic [31:0] ud1_ff [3], ax1_ff [3];
   logic        v1_ff, wr1_ff, out1_ff;
   logic [AW-1:0] widx1_ff;
   logic [VALUE_BITS-1:0] wd1_ff;
   logic        wok;
   longint      vv;

   // stage 2: partial products of offset times reciprocal
   logic [47:0] ph2_ff [3], pl2_ff [3];
   logic [31:0] ax2_ff [3];
   logic        v2_ff, wr2_ff, out2_ff;
   logic [AW-1:0] widx2_ff;
   logic [VALUE_BITS-1:0] wd2_ff;

   // stage 3: integer corner index and fraction
   logic [IW-1:0] i3_in [3], i13_in [3];
   logic [FB-1:0] t3_in [3];
   logic [IW-1:0] i3_ff [3], i13_ff [3];
   logic [FB-1:0] t3_ff [3];
   logic [31:0]   ax3_ff [3];
   logic          v3_ff, wr3_ff, out3_ff;
   logic [AW-1:0] widx3_ff;
   logic [VALUE_BITS-1:0] wd3_ff;

   // stage 4: k times res
   logic [KW-1:0] kr4_ff [2];
   logic [IW-1:0] jj4_ff [2], ii4_ff [2];
   logic [FB-1:0] t4_ff [3];
   logic [31:0]   ax4_ff [3];
   logic          v4_ff, wr4_ff, out4_ff;
   logic [AW-1:0] widx4_ff;
   logic [VALUE_BITS-1:0] wd4_ff;

   // stage 5: row bases
   logic [AW-1:0] a5_ff [4];
   logic [IW-1:0] ii5_ff [2];
   logic [FB-1:0] t5_ff [3];
   logic [31:0]   ax5_ff [3];
   logic          v5_ff, wr5_ff, out5_ff;
   logic [AW-1:0] widx5_ff;
   logic [VALUE_BITS-1:0] wd5_ff;

   logic [8*AW-1:0] addr_flat;

   assign en       = !v5_ff || !stat.full;
   assign in_ready = en;
   assign push     = v5_ff && !stat.full;

   always_comb begin
      if (cfg.grid_res < 7'd8) res = RW'(8);
      else if (32'(cfg.grid_res) > 32'(MAX_RES)) res = RW'(MAX_RES);
      else res = RW'(cfg.grid_res);
      res_m1 = IW'(res - 1'b1);
   end

   always_comb begin
      p[0] = query_x;  p[1] = query_y;  p[2] = query_z;
      lo[0] = cfg.bounds_x[31:0];  hi[0] = cfg.bounds_x[63:32];
      lo[1] = cfg.bounds_y[31:0];  hi[1] = cfg.bounds_y[63:32];
      lo[2] = cfg.bounds_z[31:0];  hi[2] = cfg.bounds_z[63:32];
      inv[0] = cfg.inv_cell_x;  inv[1] = cfg.inv_cell_y;  inv[2] = cfg.inv_cell_z;
   end

   for (genvar a = 0; a < 3; a++) begin : g_axis
      logic               below, above;
      logic signed [31:0] c;
      logic signed [32:0] d, dabs, diff;
      always_comb begin
         below = p[a] < lo[a];
         above = p[a] > hi[a];
         // an inverted box clamps to lower below it, else to upper
         c = below ? lo[a] : (above ? hi[a] : p[a]);
         in1_in[a] = !below && !above;
         d = 33'(p[a]) - 33'(c);
         dabs = d[32] ? -d : d;
         ax1_in[a] = dabs[31:0];
         diff = 33'(c) - 33'(lo[a]);
         ud1_in[a] = (!diff[32] && (diff != '0)) ? diff[31:0] : '0;
      end
   end

   always_comb begin
      wok = 64'(voxel_index) < 64'(DEPTH);
      vv  = longint'(voxel_value);
      if (vv > VMAX) vv = VMAX;
      if (vv < VMIN) vv = VMIN;
   end

   for (genvar a = 0; a < 3; a++) begin : g_coord
      logic [48:0] fsum, cap, fcl;
      always_comb begin
         fsum = {1'b0, ph2_ff[a]} + 49'(pl2_ff[a][47:FB]);
         cap  = 49'({res_m1, {FB{1'b0}}});
         fcl  = (fsum > cap) ? cap : fsum;
         i3_in[a]  = fcl[IW+FB-1:FB];
         t3_in[a]  = fcl[FB-1:0];
         i13_in[a] = (i3_in[a] == res_m1) ? i3_in[a] : IW'(i3_in[a] + 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (en) begin
         // out-of-range writes are dropped here
         v1_ff <= in_valid && (!in_write || wok);
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         wr1_ff   <= in_write;
         out1_ff  <= !(in1_in[0] && in1_in[1] && in1_in[2]);
         widx1_ff <= AW'(voxel_index);
         wd1_ff   <= VALUE_BITS'(vv);
         wr2_ff <= wr1_ff;  out2_ff <= out1_ff;  widx2_ff <= widx1_ff;  wd2_ff <= wd1_ff;
         wr3_ff <= wr2_ff;  out3_ff <= out2_ff;  widx3_ff <= widx2_ff;  wd3_ff <= wd2_ff;
         wr4_ff <= wr3_ff;  out4_ff <= out3_ff;  widx4_ff <= widx3_ff;  wd4_ff <= wd3_ff;
         wr5_ff <= wr4_ff;  out5_ff <= out4_ff;  widx5_ff <= widx4_ff;  wd5_ff <= wd4_ff;
         for (int a = 0; a < 3; a++) begin
            ud1_ff[a] <= ud1_in[a];
            ax1_ff[a] <= ax1_in[a];
            ph2_ff[a] <= 48'(ud1_ff[a][31:FB]) * 48'(inv[a]);
            pl2_ff[a] <= 48'(ud1_ff[a][FB-1:0]) * 48'(inv[a]);
            ax2_ff[a] <= ax1_ff[a];
            i3_ff[a]  <= i3_in[a];
            i13_ff[a] <= i13_in[a];
            t3_ff[a]  <= t3_in[a];
            ax3_ff[a] <= ax2_ff[a];
            t4_ff[a]  <= t3_ff[a];
            ax4_ff[a] <= ax3_ff[a];
            t5_ff[a]  <= t4_ff[a];
            ax5_ff[a] <= ax4_ff[a];
         end
         kr4_ff[0] <= KW'(KW'(i3_ff[2]) * KW'(res));
         kr4_ff[1] <= KW'(KW'(i13_ff[2]) * KW'(res));
         jj4_ff[0] <= i3_ff[1];
         jj4_ff[1] <= i13_ff[1];
         ii4_ff[0] <= i3_ff[0];
         ii4_ff[1] <= i13_ff[0];
         for (int n = 0; n < 4; n++) begin
            a5_ff[n] <= AW'(AW'(KW'(kr4_ff[n/2] + KW'(jj4_ff[n%2]))) * AW'(res));
         end
         ii5_ff <= ii4_ff;
      end
   end

   // corner b = {dz, dy, dx}; a write carries its address in corner zero
   for (genvar b = 0; b < 8; b++) begin : g_addr
      if (b == 0) begin : g_first
         assign addr_flat[AW-1:0] = wr5_ff ? widx5_ff : AW'(a5_ff[0] + AW'(ii5_ff[0]));
      end else begin : g_rest
         assign addr_flat[b*AW +: AW] = AW'(a5_ff[b/2] + AW'(ii5_ff[b%2]));
      end
   end

   assign push_data = {wr5_ff, out5_ff, addr_flat, wd5_ff,
                       t5_ff[2], t5_ff[1], t5_ff[0],
                       ax5_ff[2], ax5_ff[1], ax5_ff[0]};

endmodule

@@ hdl/tsg_isqrt.sv @@
// Pipelined 64-bit integer square root, one result bit per stage.
module tsg_isqrt (
   input  logic        clock,
   input  logic        en,
   input  logic [63:0] value,
   output logic [31:0] root
);

   localparam int NS = tsg_pkg::ISQRT_STAGES;

   logic [63:0] rem_ff [NS];
   logic [63:0] res_ff [NS];

   for (genvar s = 0; s < NS; s++) begin : g_step
      localparam logic [63:0] BIT = 64'd1 << (62 - 2 * s);
      logic [63:0] rem_i, res_i, trial;
      always_comb begin
         rem_i = (s == 0) ? value : rem_ff[(s == 0) ? 0 : s-1];
         res_i = (s == 0) ? '0    : res_ff[(s == 0) ? 0 : s-1];
         trial = res_i + BIT;
      end
      always_ff @(posedge clock) begin
         if (en) begin
            if (rem_i >= trial) begin
               rem_ff[s] <= rem_i - trial;
               res_ff[s] <= (res_i >> 1) + BIT;
            end else begin
               rem_ff[s] <= rem_i;
               res_ff[s] <= res_i >> 1;
            end
         end
      end
   end

   assign root = res_ff[NS-1][31:0];

endmodule

@@ hdl/tsg_back.sv @@
// Back end: corner memories, seven lerps, box distance and the result register.
module tsg_back #(
   parameter int MAX_RES    = tsg_pkg::MAX_RES_DEFAULT,
   parameter int VALUE_BITS = tsg_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [tsg_pkg::item_bits(3*$clog2(MAX_RES), VALUE_BITS)-1:0] pop_data,
   input  tsg_pkg::fifo_stat_type stat,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic signed [31:0]     distance,
   output logic                   was_outside
);

   localparam int IW    = $clog2(MAX_RES);
   localparam int AW    = 3 * IW;
   localparam int VB    = VALUE_BITS;
   localparam int FB    = tsg_pkg::FRAC_BITS;
   localparam int PW    = VB + FB + 2;
   localparam int DEPTH = MAX_RES * MAX_RES * MAX_RES;
   localparam int NQ    = tsg_pkg::ISQRT_STAGES;
   localparam int SD    = NQ - 4;

   typedef struct packed {
      logic valid;
      logic outside;
      logic sat;
   } bk_ctl_type;

   logic adv;
   logic is_wr, outside;
   logic [8*AW-1:0] addr_flat;
   logic [VB-1:0]   wdata;
   logic [FB-1:0]   tq [3];
   logic [31:0]     axq [3];

   logic signed [VB-1:0] c1_ff [8];
   logic          v1_ff, out1_ff;
   logic [FB-1:0] t1_ff [3];
   logic [31:0]   ax1_ff [3];

   logic signed [PW-1:0] px2_ff [4];
   logic signed [VB-1:0] e2_ff [4];
   logic [63:0]   sq2_ff [3];
   logic [FB-1:0] ty2_ff, tz2_ff;
   logic          v2_ff, out2_ff;

   logic signed [VB-1:0] a3_ff [4];
   logic [65:0]   sum3_ff;
   logic [FB-1:0] ty3_ff, tz3_ff;
   logic          v3_ff, out3_ff;

   logic signed [PW-1:0] py4_ff [2];
   logic signed [VB-1:0] e4_ff [2];
   logic [FB-1:0] tz4_ff;
   logic signed [VB-1:0] b5_ff [2];
   logic [FB-1:0] tz5_ff;
   logic signed [PW-1:0] pz6_ff;
   logic signed [VB-1:0] e6_ff;
   logic signed [VB-1:0] s7_ff;

   logic signed [VB-1:0] sdl_ff [SD];
   bk_ctl_type    ctl_ff [NQ];
   bk_ctl_type    ctl3;
   logic [31:0]   root;

   logic                 rsp_valid_ff, out_ff;
   logic signed [31:0]   dist_ff, dist_in;
   logic signed [33:0]   tot;

   assign {is_wr, outside, addr_flat, wdata, tq[2], tq[1], tq[0],
           axq[2], axq[1], axq[0]} = pop_data;

   assign adv = !rsp_valid_ff || rsp_ready;
   assign pop = adv && !stat.empty;

   // eight copies of the grid so every corner has its own read port
   for (genvar b = 0; b < 8; b++) begin : g_bank
      logic [VB-1:0] mem [DEPTH];
      always_ff @(posedge clock) begin
         if (pop) begin
            if (is_wr) mem[addr_flat[AW-1:0]] <= wdata;
            else c1_ff[b] <= mem[addr_flat[b*AW +: AW]];
         end
      end
   end

   // lerp: a + floor((b - a) * t / 2^16)
   function automatic logic signed [PW-1:0] lerp_mul(input logic signed [VB-1:0] lo_v,
                                                     input logic signed [VB-1:0] hi_v,
                                                     input logic [FB-1:0] t);
      logic signed [VB:0]   d;
      logic signed [FB:0]   ts;
      d  = (VB+1)'(hi_v) - (VB+1)'(lo_v);
      ts = signed'({1'b0, t});
      return PW'(d * ts);
   endfunction

   function automatic logic signed [VB-1:0] lerp_add(input logic signed [VB-1:0] lo_v,
                                                     input logic signed [PW-1:0] prod);
      logic signed [VB+1:0] s;
      s = (VB+2)'(lo_v) + prod[PW-1:FB];
      return s[VB-1:0];
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int n = 0; n < NQ; n++) ctl_ff[n] <= '0;
      end else if (adv) begin
         v1_ff <= pop && !is_wr;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         ctl_ff[0] <= ctl3;
         for (int n = 1; n < NQ; n++) ctl_ff[n] <= ctl_ff[n-1];
         rsp_valid_ff <= ctl_ff[NQ-1].valid;
      end
   end

   assign ctl3 = '{valid: v3_ff, outside: out3_ff, sat: sum3_ff[65:64] != 2'b00};

   always_ff @(posedge clock) begin
      if (adv) begin
         out1_ff <= outside;
         t1_ff   <= tq;
         ax1_ff  <= axq;
         out2_ff <= out1_ff;
         for (int n = 0; n < 4; n++) begin
            e2_ff[n]  <= c1_ff[2*n];
            px2_ff[n] <= lerp_mul(c1_ff[2*n], c1_ff[2*n+1], t1_ff[0]);
            a3_ff[n]  <= lerp_add(e2_ff[n], px2_ff[n]);
         end
         for (int a = 0; a < 3; a++) sq2_ff[a] <= 64'(ax1_ff[a]) * 64'(ax1_ff[a]);
         ty2_ff <= t1_ff[1];
         tz2_ff <= t1_ff[2];
         out3_ff <= out2_ff;
         sum3_ff <= 66'(sq2_ff[0]) + 66'(sq2_ff[1]) + 66'(sq2_ff[2]);
         ty3_ff <= ty2_ff;
         tz3_ff <= tz2_ff;
         for (int m = 0; m < 2; m++) begin
            e4_ff[m]  <= a3_ff[2*m];
            py4_ff[m] <= lerp_mul(a3_ff[2*m], a3_ff[2*m+1], ty3_ff);
            b5_ff[m]  <= lerp_add(e4_ff[m], py4_ff[m]);
         end
         tz4_ff <= tz3_ff;
         tz5_ff <= tz4_ff;
         e6_ff  <= b5_ff[0];
         pz6_ff <= lerp_mul(b5_ff[0], b5_ff[1], tz5_ff);
         s7_ff  <= lerp_add(e6_ff, pz6_ff);
         sdl_ff[0] <= s7_ff;
         for (int n = 1; n < SD; n++) sdl_ff[n] <= sdl_ff[n-1];
         out_ff  <= ctl_ff[NQ-1].outside;
         dist_ff <= dist_in;
      end
   end

   tsg_isqrt u_isqrt (
      .clock (clock),
      .en    (adv),
      .value (sum3_ff[63:0]),
      .root  (root)
   );

   always_comb begin
      tot = 34'(sdl_ff[SD-1]) + signed'({2'b00, root});
      if (ctl_ff[NQ-1].sat) dist_in = 32'sh7FFF_FFFF;
      else if (tot > 34'sh0_7FFF_FFFF) dist_in = 32'sh7FFF_FFFF;
      else if (tot < -34'sh0_8000_0000) dist_in = -32'sh8000_0000;
      else dist_in = tot[31:0];
   end

   assign rsp_valid   = rsp_valid_ff;
   assign distance    = dist_ff;
   assign was_outside = out_ff;

endmodule

@@ tb/trilinear_sdf_grid_sampler_tb.sv @@
// Self-checking testbench for the trilinear SDF grid sampler.
`timescale 1ns / 100ps

module trilinear_sdf_grid_sampler_tb;

   localparam int GRID_DEPTH = 64 * 64 * 64;
   localparam int SETTLE_CYCLES = 80;
   localparam int STALL_LIMIT = 20000;
   localparam logic [tsg_pkg::CSR_INDEX_BITS-1:0] CSR_UNUSED = 3'd7;
   localparam logic REQ_QUERY = 1'b0;
   localparam logic REQ_WRITE = 1'b1;

   typedef int unsigned corner_list_type [8];
   typedef struct {
      logic [31:0] dist_val;
      logic        outside;
   } sample_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [151:0] req_tdata = '0;
   logic         req_tuser = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [31:0]  rsp_tdata;
   logic         rsp_tuser;
   logic         csr_we = 1'b0;
   logic [tsg_pkg::CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [63:0]  csr_wdata = '0;

   // predictor state
   logic [63:0] box [3];
   logic [31:0] inv_cell [3];
   logic [6:0]  res_reg;
   int          grid [GRID_DEPTH];
   bit          written [GRID_DEPTH];

   sample_type  pending_samples [$];
   int          fail_count = 0;
   int          send_idle_pct = 0;
   int          stall_pct = 0;
   int          hold_token = 0;
   int          hold_seen = 0;
   int          hold_cnt = 0;
   int          quiet_cycles = 0;
   int          beat_count = 0;

   trilinear_sdf_grid_sampler i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #2 clock = ~clock;

   function automatic longint lerp16(longint a, longint b, longint t);
      return a + (((b - a) * t) >>> 16);
   endfunction

   function automatic longint unsigned root64(longint unsigned v);
      longint unsigned acc = 0;
      longint unsigned b = 64'h4000_0000_0000_0000;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= acc + b) begin
            v = v - (acc + b);
            acc = (acc >> 1) + b;
         end else begin
            acc = acc >> 1;
         end
         b = b >> 2;
      end
      return acc;
   endfunction

   // Trilinear sample plus box distance for one query point.
   function automatic void sample_point(input logic [31:0] pt [3], output sample_type smp,
                                        output corner_list_type corner);
      longint lo, hi, p, c, diff, f, cap, inv, s, total;
      longint unsigned ax;
      longint t [3];
      int unsigned i0 [3], i1 [3];
      int unsigned r, ix, iy, iz;
      longint v [8];
      logic [65:0] sq;
      bit in_box;
      r = res_reg < 8 ? 8 : (res_reg > 64 ? 64 : res_reg);
      sq = '0;
      in_box = 1'b1;
      for (int a = 0; a < 3; a++) begin
         lo = longint'($signed(box[a][31:0]));
         hi = longint'($signed(box[a][63:32]));
         p = longint'($signed(pt[a]));
         if (p < lo || p > hi) in_box = 1'b0;
         c = p < lo ? lo : (p > hi ? hi : p);
         ax = (p - c) < 0 ? longint'(c - p) : longint'(p - c);
         sq = sq + 66'(ax) * 66'(ax);
         diff = c - lo;
         inv = longint'({32'd0, inv_cell[a]});
         f = 0;
         if (diff > 0) f = (diff >> 16) * inv + (((diff & 'hFFFF) * inv) >> 16);
         cap = longint'(r - 1) << 16;
         if (f > cap) f = cap;
         t[a] = f & 'hFFFF;
         i0[a] = int'(f >> 16);
         i1[a] = (i0[a] + 1 < r) ? i0[a] + 1 : r - 1;
      end
      for (int n = 0; n < 8; n++) begin
         ix = n[0] ? i1[0] : i0[0];
         iy = n[1] ? i1[1] : i0[1];
         iz = n[2] ? i1[2] : i0[2];
         corner[n] = (iz * r + iy) * r + ix;
         v[n] = longint'(grid[corner[n]]);
      end
      s = lerp16(lerp16(lerp16(v[0], v[1], t[0]), lerp16(v[2], v[3], t[0]), t[1]),
                 lerp16(lerp16(v[4], v[5], t[0]), lerp16(v[6], v[7], t[0]), t[1]), t[2]);
      if (sq[65:64] != 2'b00) begin
         total = 64'sd2147483647;
      end else begin
         total = s + longint'(root64(sq[63:0]));
         if (total > 64'sd2147483647) total = 64'sd2147483647;
         if (total < -64'sd2147483648) total = -64'sd2147483648;
      end
      smp.dist_val = total[31:0];
      smp.outside = ~in_box;
   endfunction

   // result checker
   always @(posedge clock) begin
      sample_type exp_s;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_samples.size() == 0) begin
            $error("unexpected result beat: distance %h", rsp_tdata);
            fail_count++;
         end else begin
            exp_s = pending_samples.pop_front();
            if (rsp_tdata !== exp_s.dist_val) begin
               $error("distance: expected %h, got %h", exp_s.dist_val, rsp_tdata);
               fail_count++;
            end
            if (rsp_tuser !== exp_s.outside) begin
               $error("was_outside: expected %b, got %b", exp_s.outside, rsp_tuser);
               fail_count++;
            end
         end
      end
   end

   // result side: random stalls, or a long hold-off on request
   always @(posedge clock) begin
      if (hold_token != hold_seen) begin
         hold_seen <= hold_token;
         hold_cnt <= 500;
         rsp_tready <= 1'b0;
      end else if (hold_cnt > 0) begin
         hold_cnt <= hold_cnt - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic push_beat(logic kind, logic [151:0] data);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= data;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      beat_count++;
   endtask

   task automatic write_voxel(logic [17:0] idx, logic [31:0] val);
      push_beat(REQ_WRITE, {6'd0, val, idx, 96'd0});
      grid[idx] = val;
      written[idx] = 1'b1;
   endtask

   function automatic logic [31:0] rand_value();
      if ($urandom_range(7) == 0) return $urandom;
      return 32'($urandom_range(0, 20 << 16)) - 32'(10 << 16);
   endfunction

   // Fill any unwritten corner first, then send the query.
   task automatic query(logic [31:0] x, logic [31:0] y, logic [31:0] z);
      logic [31:0] pt [3];
      sample_type smp;
      corner_list_type corner;
      pt[0] = x;
      pt[1] = y;
      pt[2] = z;
      sample_point(pt, smp, corner);
      for (int n = 0; n < 8; n++)
         if (!written[corner[n]]) write_voxel(corner[n][17:0], rand_value());
      push_beat(REQ_QUERY, {56'd0, z, y, x});
      sample_point(pt, smp, corner);
      pending_samples = {pending_samples, smp};
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_samples.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_reg(logic [tsg_pkg::CSR_INDEX_BITS-1:0] idx, logic [63:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   // Writes every register; only called with the block idle.
   task automatic apply_config(logic [63:0] bx, logic [63:0] by, logic [63:0] bz,
                               logic [31:0] ivx, logic [31:0] ivy, logic [31:0] ivz,
                               logic [6:0] res);
      set_reg(tsg_pkg::CSR_BOUNDS_X, bx);
      set_reg(tsg_pkg::CSR_BOUNDS_Y, by);
      set_reg(tsg_pkg::CSR_BOUNDS_Z, bz);
      set_reg(tsg_pkg::CSR_INV_CELL_X, {32'd0, ivx});
      set_reg(tsg_pkg::CSR_INV_CELL_Y, {32'd0, ivy});
      set_reg(tsg_pkg::CSR_INV_CELL_Z, {32'd0, ivz});
      set_reg(tsg_pkg::CSR_GRID_RES, {57'd0, res});
      set_reg(CSR_UNUSED, $urandom);   // index past the register list, ignored
      csr_we <= 1'b0;
      box[0] = bx;
      box[1] = by;
      box[2] = bz;
      inv_cell[0] = ivx;
      inv_cell[1] = ivy;
      inv_cell[2] = ivz;
      res_reg = res;
   endtask

   function automatic logic [63:0] span(int lo_units, int hi_units);
      return {32'(hi_units << 16), 32'(lo_units << 16)};
   endfunction

   task automatic unit_box(logic [6:0] res);
      apply_config(span(0, 7), span(0, 7), span(0, 7), 32'h1_0000, 32'h1_0000, 32'h1_0000,
                   res);
   endtask

   task automatic random_config();
      logic [63:0] bx [3];
      logic [31:0] iv [3];
      logic [31:0] lo, w;
      logic [6:0] res;
      case ($urandom_range(3))
         0: res = 7'd8;
         1: res = 7'd64;
         default: res = $urandom_range(0, 127);
      endcase
      for (int a = 0; a < 3; a++) begin
         lo = 32'($urandom_range(0, 200 << 16)) - 32'(100 << 16);
         w = $urandom_range(1 << 16, 64 << 16);
         bx[a] = ($urandom_range(5) == 0) ? {lo, lo + w} : {lo + w, lo};
         case ($urandom_range(9))
            0: iv[a] = 32'd0;
            1: iv[a] = 32'hFFFF_FFFF;
            default: iv[a] = $urandom_range(1 << 12, 1 << 22);
         endcase
      end
      apply_config(bx[0], bx[1], bx[2], iv[0], iv[1], iv[2], res);
   endtask

   function automatic logic [31:0] rand_coord(int a);
      logic [31:0] lo, hi, w;
      if ($urandom_range(4) == 0) return $urandom;
      lo = box[a][31:0];
      hi = box[a][63:32];
      if ($signed(hi) < $signed(lo)) begin
         lo = box[a][63:32];
         hi = box[a][31:0];
      end
      w = hi - lo;
      return lo - (w >> 2) + $urandom_range(0, w + (w >> 1));
   endfunction

   task automatic test_basic_queries();
      unit_box(7'd8);
      write_voxel(18'd0, 32'h7FFF_FFFF);
      write_voxel(18'd1, 32'h8000_0000);
      write_voxel(18'd8, 32'h0003_8000);
      write_voxel(18'd64, 32'hFFFC_0000);
      query(32'h0, 32'h0, 32'h0);
      query(32'h0000_8000, 32'h0, 32'h0);           // blend across the full value range
      query(32'h0000_4000, 32'h0000_C000, 32'h0000_2000);
      query(32'h0007_0000, 32'h0007_0000, 32'h0007_0000); // upper corner clamp
      query(32'h0003_8000, 32'h0002_4000, 32'h0006_C000);
      query(32'hFFFD_0000, 32'h0, 32'h0);           // outside on x only
      query(32'h0, 32'h000A_0000, 32'hFFFF_0000);
      query(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      query(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF); // max value plus offset saturates
      drain();
   endtask

   task automatic test_special_cases();
      // sum of squares past 64 bits
      apply_config({2{32'h7FFF_FFFF}}, {2{32'h7FFF_FFFF}}, {2{32'h7FFF_FFFF}},
                   32'h1_0000, 32'h1_0000, 32'h1_0000, 7'd64);
      query(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      query(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      drain();
      // inverted box: everything is outside
      apply_config(span(5, 2), span(0, 7), span(0, 7), 32'h1_0000, 32'h1_0000, 32'h1_0000,
                   7'd0);
      query(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
      query(32'h0006_0000, 32'h0001_0000, 32'h0001_0000);
      query(32'h0003_8000, 32'h0003_0000, 32'h0003_0000);
      drain();
      // full-range box, extreme reciprocals, resolution over the top
      apply_config({32'h7FFF_FFFF, 32'h8000_0000}, span(-20, 20), span(0, 7),
                   32'hFFFF_FFFF, 32'd0, 32'h0000_0001, 7'd127);
      query(32'h0, 32'h0, 32'h0003_0000);
      query(32'h8000_0000, 32'h0014_0000, 32'h0007_0000);
      query(32'h7FFF_FFFF, 32'hFFEC_0000, 32'h0);
      write_voxel(18'h3FFFF, 32'h7FFF_FFFF);
      write_voxel(18'h2AAAA, 32'h8000_0000);
      drain();
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0;
      stall_pct = 0;
      unit_box(7'd8);
      for (int i = 0; i < 512; i++)
         if (!written[i]) write_voxel(18'(i), rand_value());
      hold_token++;
      for (int i = 0; i < 200; i++)
         query($urandom_range(0, 8 << 16), $urandom_range(0, 8 << 16),
               $urandom_range(0, 8 << 16));
      drain();
   endtask

   // count is in beats, corner fills included
   task automatic test_random_traffic(int idle, int stall, int count);
      int first;
      int i;
      send_idle_pct = idle;
      stall_pct = stall;
      first = beat_count;
      i = 0;
      while (beat_count - first < count) begin
         if (i % 25 == 0) begin
            drain();
            random_config();
         end
         if ($urandom_range(9) == 0)
            write_voxel(18'($urandom_range(0, GRID_DEPTH - 1)), $urandom);
         else query(rand_coord(0), rand_coord(1), rand_coord(2));
         i++;
      end
      drain();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_basic_queries();
      test_special_cases();
      test_backpressure();
      test_random_traffic(0, 0, 320);
      test_random_traffic(57, 0, 320);
      test_random_traffic(0, 57, 320);
      test_random_traffic(24, 24, 320);
      while (pending_samples.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (fail_count == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

endmodule
